// File: hdl/stunv_pkg.sv
// stunv_pkg: shared types, constants and the byte-wise crc-32 function
// for the stun message validator; no dependencies
`default_nettype none

package stunv_pkg;

  // default width of the saturating byte counter
  localparam int COUNT_BITS_DEF = 17;

  // attribute offsets and message end positions are 18 bits wide
  localparam int OFF_BITS = 18;

  localparam logic [OFF_BITS-1:0] HDR_BYTES = 18'd20;
  localparam logic [31:0] STUN_COOKIE  = 32'h2112_A442;
  localparam logic [15:0] FP_TYPE      = 16'h8028;
  localparam logic [31:0] FP_XOR       = 32'h5354_554E;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [15:0] TYPE_MASK    = 16'hC000;
  localparam logic [15:0] FP_LEN       = 16'd4;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_LENGTH      = 3'd1,
    ST_COOKIE      = 3'd2,
    ST_MISMATCH    = 3'd3,
    ST_TYPE        = 3'd4,
    ST_ATTR_LEN    = 3'd5,
    ST_FP_NOT_LAST = 3'd6,
    ST_FP_BAD      = 3'd7
  } status_t;

  // one input beat as it leaves the input register
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // verdict for a message, valid on its last beat
  typedef struct packed {
    status_t status;
    logic    fp_seen;
  } result_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/stunv_msg_state.sv
// stunv_msg_state: per-message state (count, crc, header, attribute walk)
// and the end-of-message verdict; depends on stunv_pkg
`default_nettype none

module stunv_msg_state #(
  parameter int COUNT_BITS = stunv_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire stunv_pkg::beat_t  beat,
  output stunv_pkg::result_t     result
);
  import stunv_pkg::*;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [31:0]           crc_r, crc_nxt;
  logic [31:0]           hs_r, hs_nxt;
  logic [15:0]           dl_r, dl_nxt;
  logic [OFF_BITS-1:0]   nao_r, nao_nxt;
  logic [31:0]           claim_r, claim_nxt;
  logic [31:0]           cbf_r, cbf_nxt;
  status_t               fe_r, fe_nxt;
  logic [1:0]            flags_r, flags_nxt;

  logic [OFF_BITS-1:0]   pos;
  logic [OFF_BITS-1:0]   msg_end;
  logic [OFF_BITS-1:0]   n_bytes;
  logic [16:0]           alen_pad;
  logic [OFF_BITS:0]     next_off;
  logic [31:0]           fp_expect;
  status_t               st;

  always_comb begin
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    hs_nxt    = hs_r;
    dl_nxt    = dl_r;
    nao_nxt   = nao_r;
    claim_nxt = claim_r;
    cbf_nxt   = cbf_r;
    fe_nxt    = fe_r;
    flags_nxt = flags_r;
    pos       = {{(OFF_BITS-COUNT_BITS){1'b0}}, cnt_r};
    msg_end   = HDR_BYTES + {2'b00, dl_r};
    alen_pad  = 17'd0;
    next_off  = '0;

    if (!(&cnt_r)) begin
      // crc at the start of each attribute, kept for the fingerprint
      if (pos >= HDR_BYTES && pos == nao_r) begin
        cbf_nxt = crc_r;
      end
      hs_nxt  = {hs_r[23:0], beat.data};
      crc_nxt = crc_byte(crc_r, beat.data);
      if (pos == 18'd1 && (hs_nxt[15:0] & TYPE_MASK) != 16'd0) begin
        fe_nxt = ST_TYPE;
      end
      if (pos == 18'd3) begin
        dl_nxt = hs_nxt[15:0];
      end
      if (pos == 18'd7 && hs_nxt != STUN_COOKIE) begin
        fe_nxt = ST_COOKIE;
      end
      msg_end = HDR_BYTES + {2'b00, dl_nxt};

      if (fe_nxt == ST_OK) begin
        // last four bytes of the message are the fingerprint value
        if (flags_nxt[0] && (pos + 18'd1) == msg_end) begin
          claim_nxt    = hs_nxt;
          flags_nxt[1] = 1'b1;
        end
        if (pos >= HDR_BYTES && nao_r < msg_end &&
            {1'b0, pos} == ({1'b0, nao_r} + 19'd3)) begin
          alen_pad = ({1'b0, hs_nxt[15:0]} + 17'd3) & ~17'd3;
          next_off = {1'b0, nao_r} + 19'd4 + {2'b00, alen_pad};
          if (next_off > {1'b0, msg_end}) begin
            fe_nxt = ST_ATTR_LEN;
          end else if (hs_nxt[31:16] == FP_TYPE) begin
            flags_nxt[0] = 1'b1;
            if (next_off != {1'b0, msg_end}) begin
              fe_nxt = ST_FP_NOT_LAST;
            end else if (hs_nxt[15:0] != FP_LEN) begin
              fe_nxt = ST_ATTR_LEN;
            end
          end
          nao_nxt = next_off[OFF_BITS-1:0];
        end
      end
      cnt_nxt = cnt_r + COUNT_BITS'(1);
    end

    // verdict from the updated state, ranked
    n_bytes   = {{(OFF_BITS-COUNT_BITS){1'b0}}, cnt_nxt};
    fp_expect = FP_XOR ^ ~cbf_nxt;
    if (n_bytes < HDR_BYTES || n_bytes[1:0] != 2'b00) begin
      st = ST_LENGTH;
    end else if (fe_nxt == ST_COOKIE) begin
      st = ST_COOKIE;
    end else if (n_bytes != msg_end) begin
      st = ST_MISMATCH;
    end else if (fe_nxt != ST_OK) begin
      st = fe_nxt;
    end else if (flags_nxt[0]) begin
      st = (flags_nxt[1] && claim_nxt == fp_expect) ? ST_OK : ST_FP_BAD;
    end else begin
      st = ST_OK;
    end
    result.status  = st;
    result.fp_seen = (st == ST_LENGTH || st == ST_COOKIE || st == ST_MISMATCH ||
                      st == ST_TYPE) ? 1'b0 : flags_nxt[0];

    // message closed: start over
    if (beat.last) begin
      cnt_nxt   = '0;
      crc_nxt   = CRC_INIT;
      hs_nxt    = '0;
      dl_nxt    = '0;
      nao_nxt   = HDR_BYTES;
      claim_nxt = '0;
      cbf_nxt   = '0;
      fe_nxt    = ST_OK;
      flags_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      crc_r   <= CRC_INIT;
      hs_r    <= '0;
      dl_r    <= '0;
      nao_r   <= HDR_BYTES;
      claim_r <= '0;
      cbf_r   <= '0;
      fe_r    <= ST_OK;
      flags_r <= '0;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      hs_r    <= hs_nxt;
      dl_r    <= dl_nxt;
      nao_r   <= nao_nxt;
      claim_r <= claim_nxt;
      cbf_r   <= cbf_nxt;
      fe_r    <= fe_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/stun_message_validator.sv
// stun_message_validator: one message byte per beat in, one verdict beat per message out
// path: an accepted last byte goes through the input register, then the result register, to out_valid
// throughput: one byte per cycle, set by the crc/walk logic, unless a last byte is held back
// while a verdict waits in the output register, only a last byte holds up the input register
// reset (rst_n low, synchronous) empties both registers and restarts message state
`default_nettype none

module stun_message_validator #(
  parameter int COUNT_BITS = stunv_pkg::COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic            out_fingerprint_seen
);
  import stunv_pkg::*;

  // input register
  logic    s1_valid_r, s1_valid_nxt;
  beat_t   s1_beat_r;
  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic    in_fire;
  logic    advance;
  result_t res;

  // a byte that is not last never waits; a last byte waits for a free result slot
  assign advance  = s1_valid_r && (!s1_beat_r.last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && s1_beat_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // message state and verdict logic
  stunv_msg_state #(
    .COUNT_BITS (COUNT_BITS)
  ) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .beat   (s1_beat_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_beat_r.data <= in_data_byte;
      s1_beat_r.last <= in_last_byte;
    end
    if (advance && s1_beat_r.last) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_fingerprint_seen = out_res_r.fp_seen;

endmodule

`default_nettype wire

// File: sim/stunv_checker.sv
// stunv_checker: watches both channels of the stun message validator, predicts each verdict
// from the accepted byte beats and compares it with the verdict beats that leave the block
// depends on stunv_pkg for the status codes, the result layout and the protocol constants
module stunv_checker #(
  parameter int COUNT_BITS = stunv_pkg::COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [2:0] out_status,
  input  wire logic       out_fingerprint_seen,
  output int              fail_count,
  output int              pending
);
  import stunv_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

  // message state of the predictor
  logic [COUNT_BITS-1:0] byte_cnt;
  logic [31:0]           crc_acc;
  logic [31:0]           window;
  logic [15:0]           decl_len;
  logic [OFF_BITS-1:0]   attr_off;
  logic [31:0]           fp_claim;
  logic [31:0]           crc_at_attr;
  status_t               first_err;
  logic                  fp_found;
  logic                  claim_held;

  result_t verdict_q[$];
  result_t want;
  int      errors = 0;

  // reflected crc-32, one data bit per step
  function automatic logic [31:0] crc_shift_in(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  task automatic clear_state();
    byte_cnt    = '0;
    crc_acc     = CRC_INIT;
    window      = '0;
    decl_len    = '0;
    attr_off    = HDR_BYTES;
    fp_claim    = '0;
    crc_at_attr = '0;
    first_err   = ST_OK;
    fp_found    = 1'b0;
    claim_held  = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] d, input logic lst);
    logic [OFF_BITS-1:0] p;
    logic [OFF_BITS-1:0] msg_end;
    logic [OFF_BITS-1:0] nxt;
    logic [15:0]         atype;
    logic [15:0]         alen;
    status_t             st;
    result_t             r;
    if (byte_cnt != CNT_TOP) begin
      p = OFF_BITS'(byte_cnt);
      // crc register as it stands at the start of each attribute
      if (p >= HDR_BYTES && p == attr_off) crc_at_attr = crc_acc;
      window  = {window[23:0], d};
      crc_acc = crc_shift_in(crc_acc, d);
      if (p == 1 && (window[15:0] & TYPE_MASK) != 16'd0) first_err = ST_TYPE;
      if (p == 3) decl_len = window[15:0];
      if (p == 7 && window != STUN_COOKIE) first_err = ST_COOKIE;
      msg_end = HDR_BYTES + OFF_BITS'(decl_len);
      // attribute walk, frozen by the first error
      if (first_err == ST_OK) begin
        if (fp_found && p + 1 == msg_end) begin
          fp_claim   = window;
          claim_held = 1'b1;
        end
        if (p >= HDR_BYTES && attr_off < msg_end && p == attr_off + 3) begin
          atype = window[31:16];
          alen  = window[15:0];
          nxt   = attr_off + OFF_BITS'(4) + ((OFF_BITS'(alen) + OFF_BITS'(3)) & ~OFF_BITS'(3));
          if (nxt > msg_end) begin
            first_err = ST_ATTR_LEN;
          end else if (atype == FP_TYPE) begin
            fp_found = 1'b1;
            if (nxt != msg_end) first_err = ST_FP_NOT_LAST;
            else if (alen != FP_LEN) first_err = ST_ATTR_LEN;
          end
          attr_off = nxt;
        end
      end
      byte_cnt = byte_cnt + 1'b1;
    end

    if (lst) begin
      msg_end = HDR_BYTES + OFF_BITS'(decl_len);
      if (byte_cnt < HDR_BYTES || byte_cnt[1:0] != 2'd0) st = ST_LENGTH;
      else if (first_err == ST_COOKIE) st = ST_COOKIE;
      else if (OFF_BITS'(byte_cnt) != msg_end) st = ST_MISMATCH;
      else if (first_err != ST_OK) st = first_err;
      else if (fp_found && !(claim_held && fp_claim == (FP_XOR ^ ~crc_at_attr))) st = ST_FP_BAD;
      else st = ST_OK;
      r.status  = st;
      r.fp_seen = (st >= ST_LENGTH && st <= ST_TYPE) ? 1'b0 : fp_found;
      verdict_q.push_back(r);
      clear_state();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      verdict_q.delete();
    end else begin
      if (in_valid && in_ready) absorb_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict beat with none expected: status %0d fingerprint_seen %0d",
                 out_status, out_fingerprint_seen);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errors++;
          end
          if (out_fingerprint_seen !== want.fp_seen) begin
            $error("fingerprint_seen: expected %0d, actual %0d", want.fp_seen,
                   out_fingerprint_seen);
            errors++;
          end
        end
      end
    end
    pending    <= verdict_q.size();
    fail_count <= errors;
  end

endmodule

// File: sim/tb_top.sv
// tb_top: drives stun messages into stun_message_validator, well-formed and broken,
// under three idling patterns; depends on stunv_pkg, the block and stunv_checker
module tb_top;
  import stunv_pkg::*;

  // longest run of cycles with no beat on either channel before giving up
  localparam int STALL_LIMIT  = 2000;
  // two register stages in the block, plus margin
  localparam int DRAIN_CYCLES = 8;
  // each random phase stops once both of these are reached
  localparam int PHASE_BYTES  = 240;
  localparam int PHASE_MSGS   = 8;

  typedef enum int {
    MSG_PLAIN,
    MSG_FP,
    MSG_SHORT,
    MSG_UNALIGNED,
    MSG_COOKIE,
    MSG_LEN_MISMATCH,
    MSG_BAD_MTYPE,
    MSG_ATTR_OVERRUN,
    MSG_FP_NOT_LAST,
    MSG_FP_LEN,
    MSG_FP_BAD,
    MSG_NOISE
  } msg_kind_t;

  logic       clk;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte  = 8'd0;
  logic       in_last_byte  = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [2:0] out_status;
  logic       out_fingerprint_seen;

  int fail_count;
  int pending;

  // message under construction
  logic [7:0] hdr_q[$];
  logic [7:0] body_q[$];
  logic [7:0] msg_q[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int sent_bytes;
  int sent_msgs;

  stun_message_validator u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_fingerprint_seen (out_fingerprint_seen)
  );

  stunv_checker u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_fingerprint_seen (out_fingerprint_seen),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls at random, per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // attribute header plus value, value padded out to a multiple of four bytes with random fill
  task automatic add_attr(input logic [15:0] atype, input logic [15:0] alen);
    int span;
    span = (int'(alen) + 3) & ~3;
    body_q.push_back(atype[15:8]);
    body_q.push_back(atype[7:0]);
    body_q.push_back(alen[15:8]);
    body_q.push_back(alen[7:0]);
    repeat (span) body_q.push_back(8'($urandom));
  endtask

  // any attribute type but the fingerprint
  function automatic logic [15:0] plain_atype();
    logic [15:0] t;
    t = 16'($urandom);
    if (t == FP_TYPE) t = t ^ 16'd1;
    return t;
  endfunction

  // builds one message of the given kind into msg_q
  task automatic build_msg(input msg_kind_t kind);
    int          n_attr;
    int          len_pos;
    int          fp_len;
    int          fp_span;
    int          tail_len;
    int          tail_span;
    int          keep;
    logic        with_fp;
    logic [15:0] mtype;
    logic [15:0] decl;
    logic [15:0] old_len;
    logic [31:0] cookie;
    logic [31:0] crc;
    logic [31:0] fp_val;

    msg_q.delete();
    if (kind == MSG_NOISE) begin
      repeat ($urandom_range(1, 48)) msg_q.push_back(8'($urandom));
      return;
    end

    // header: type with clear top bits unless bad-type, length filled in later, cookie, transaction id
    mtype = 16'($urandom) & ~TYPE_MASK;
    if (kind == MSG_BAD_MTYPE) mtype[15:14] = 2'($urandom_range(1, 3));
    cookie = STUN_COOKIE;
    if (kind == MSG_COOKIE) cookie = cookie ^ (32'd1 << $urandom_range(0, 31));
    hdr_q = {mtype[15:8], mtype[7:0], 8'h00, 8'h00,
             cookie[31:24], cookie[23:16], cookie[15:8], cookie[7:0]};
    repeat (12) hdr_q.push_back(8'($urandom));

    body_q.delete();
    len_pos = -1;
    n_attr  = $urandom_range((kind == MSG_ATTR_OVERRUN) ? 1 : 0, 2);
    repeat (n_attr) begin
      len_pos = body_q.size() + 2;
      add_attr(plain_atype(), 16'($urandom_range(0, 10)));
    end

    // fingerprint is always there for its own kinds, never on plain or overrun
    if (kind == MSG_FP || kind == MSG_FP_NOT_LAST || kind == MSG_FP_LEN || kind == MSG_FP_BAD)
      with_fp = 1'b1;
    else if (kind == MSG_PLAIN || kind == MSG_ATTR_OVERRUN)
      with_fp = 1'b0;
    else
      with_fp = 1'($urandom);

    fp_len = 4;
    if (kind == MSG_FP_LEN)
      fp_len = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(5, 12);
    fp_span   = with_fp ? 4 + ((fp_len + 3) & ~3) : 0;
    tail_len  = $urandom_range(0, 8);
    tail_span = (kind == MSG_FP_NOT_LAST) ? 4 + ((tail_len + 3) & ~3) : 0;

    decl = 16'(body_q.size() + fp_span + tail_span);
    if (kind == MSG_LEN_MISMATCH) begin
      if (decl >= 16'd8 && $urandom_range(0, 1)) decl = decl - 16'(4 * $urandom_range(1, 2));
      else decl = decl + 16'(4 * $urandom_range(1, 3));
    end
    hdr_q[2] = decl[15:8];
    hdr_q[3] = decl[7:0];

    // last attribute claims more than the message holds
    if (kind == MSG_ATTR_OVERRUN) begin
      old_len = {body_q[len_pos], body_q[len_pos+1]};
      if ($urandom_range(0, 1)) old_len = 16'hFFFF;
      else old_len = old_len + 16'(4 * $urandom_range(1, 4));
      body_q[len_pos]   = old_len[15:8];
      body_q[len_pos+1] = old_len[7:0];
    end

    msg_q = {hdr_q, body_q};

    if (with_fp) begin
      crc = CRC_INIT;
      foreach (msg_q[i]) crc = crc_byte(crc, msg_q[i]);
      fp_val = FP_XOR ^ ~crc;
      if (kind == MSG_FP_BAD) fp_val = fp_val ^ (32'd1 << $urandom_range(0, 31));
      body_q = {FP_TYPE[15:8], FP_TYPE[7:0], 8'(fp_len >> 8), 8'(fp_len),
                fp_val[31:24], fp_val[23:16], fp_val[15:8], fp_val[7:0]};
      repeat (fp_span - 8) body_q.push_back(8'($urandom));
      if (kind == MSG_FP_NOT_LAST) add_attr(plain_atype(), 16'(tail_len));
      msg_q = {msg_q, body_q};
    end

    if (kind == MSG_UNALIGNED) repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom));
    if (kind == MSG_SHORT) begin
      keep = $urandom_range(1, 19);
      while (msg_q.size() > keep) void'(msg_q.pop_back());
    end
  endtask

  // one beat per byte, last flagged; valid stays up across beats unless the sender idles
  task automatic send_msg();
    foreach (msg_q[i]) begin
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= msg_q[i];
      in_last_byte <= (i == msg_q.size() - 1);
      do @(posedge clk); while (!in_ready);
    end
    sent_bytes += msg_q.size();
    sent_msgs++;
  endtask

  // random messages, mostly well-formed, the rest spread over the broken kinds
  task automatic run_phase(input int tx_pct, input int rx_pct);
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent_bytes  = 0;
    sent_msgs   = 0;
    while (sent_bytes < PHASE_BYTES || sent_msgs < PHASE_MSGS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) build_msg(MSG_PLAIN);
      else if (pick < 55) build_msg(MSG_FP);
      else build_msg(msg_kind_t'($urandom_range(int'(MSG_SHORT), int'(MSG_NOISE))));
      send_msg();
    end
  endtask

  // watchdog: ends the run after too many cycles without a beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL stun_message_validator");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every message kind once, sender busy, receiver slow
    tx_idle_pct = 7;
    rx_idle_pct = 84;
    for (int k = 0; k <= int'(MSG_NOISE); k++) begin
      build_msg(msg_kind_t'(k));
      send_msg();
    end

    run_phase(7, 84);
    run_phase(84, 7);
    run_phase(0, 0);
    in_valid <= 1'b0;

    // let the checker see the last beat, then drain the verdicts
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS stun_message_validator");
    end else begin
      $display("FAIL stun_message_validator");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/stunv_pkg.sv
hdl/stunv_msg_state.sv
hdl/stun_message_validator.sv
sim/stunv_checker.sv
sim/tb_top.sv
